@@ src/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int MODE_W    = 2;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Control decisions of the pointer logic for one operation.
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    logic    pop_ok;
    status_t status;
  } op_ctrl_t;

endpackage

@@ src/deq_if.sv @@
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::MODE_W-1:0]          mode;
  logic signed [deq_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface deq_out_if #(
  parameter int OCC_W = 7
);
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::DATA_W-1:0]   pop_value;
  logic [deq_pkg::STATUS_W-1:0]        status;
  logic [OCC_W-1:0]                    occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

@@ src/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit values held in a ring memory.
// ----------------------------------------------------------------------------
// An accepted operation beat passes the ring read stage, then the output
// register, before its result beat is offered. Throughput: one operation per
// cycle unless the result channel stalls; the pointers update at acceptance
// and the single-port ring memory takes one write or one read per beat.
// Reset: synchronous active-low reset empties the queue (front index and count
// cleared); ring contents are not cleared and need no clearing pass.
module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  deq_pkg::op_ctrl_t           ctrl;
  logic [AW-1:0]               slot;
  logic [CW-1:0]               occ_nxt;
  logic [deq_pkg::DATA_W-1:0]  rd_data;
  logic                        accept;
  logic                        s1_adv;
  logic                        out_free;

  // Stage 1: waits for the ring read data.
  logic                        s1_valid_r;
  logic                        s1_pop_ok_r;
  logic [deq_pkg::STATUS_W-1:0] s1_status_r;
  logic [CW-1:0]               s1_occ_r;

  // Output register.
  logic                        out_valid_r;
  logic [deq_pkg::DATA_W-1:0]  out_pop_value_r;
  logic [deq_pkg::STATUS_W-1:0] out_status_r;
  logic [CW-1:0]               out_occ_r;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign accept       = in_ch.valid && in_ch.ready;

  deq_ptr #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ptr (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .mode    (in_ch.mode),
    .ctrl    (ctrl),
    .slot    (slot),
    .occ_nxt (occ_nxt)
  );

  // The read register only loads on an accepted pop, so it holds while the
  // stage stalls.
  deq_ring_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && ctrl.wr_en),
    .rd_en   (accept && ctrl.rd_en),
    .addr    (slot),
    .wr_data (in_ch.push_value),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop_ok_r <= ctrl.pop_ok;
      s1_status_r <= ctrl.status;
      s1_occ_r    <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pop_value_r <= s1_pop_ok_r ? rd_data : '0;
      out_status_r    <= s1_status_r;
      out_occ_r       <= s1_occ_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pop_value = out_pop_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != deq_pkg::STATUS_DONE) |-> (out_pop_value_r == '0))
    else $error("refused operation returned a nonzero value");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == deq_pkg::STATUS_FULL) |-> (out_occ_r == CW'(DEPTH)))
    else $error("full status with queue not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == deq_pkg::STATUS_EMPTY) |-> (out_occ_r == '0))
    else $error("empty status with queue not empty");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled while the pipeline can move");

endmodule

@@ src/deq_ring_mem.sv @@
// ----------------------------------------------------------------------------
// deq_ring_mem
// Single-port synchronous ring storage with a registered read.
// ----------------------------------------------------------------------------
module deq_ring_mem #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic                        rd_en,
  input  logic [AW-1:0]               addr,
  input  logic [deq_pkg::DATA_W-1:0]  wr_data,
  output logic [deq_pkg::DATA_W-1:0]  rd_data
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [deq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/deq_ptr.sv @@
// ----------------------------------------------------------------------------
// deq_ptr
// Front index and entry count; picks the ring slot and status of each beat.
// ----------------------------------------------------------------------------
module deq_ptr #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [deq_pkg::MODE_W-1:0]  mode,
  output deq_pkg::op_ctrl_t           ctrl,
  output logic [AW-1:0]               slot,
  output logic [CW-1:0]               occ_nxt
);

  localparam int SW = AW + 1;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          full, empty;
  logic [AW-1:0] front_dec, front_inc;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] offset);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(offset);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);

  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    slot        = front_r;
    ctrl        = '0;
    ctrl.status = deq_pkg::STATUS_DONE;
    unique case (deq_pkg::mode_t'(mode))
      deq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          ctrl.status = deq_pkg::STATUS_FULL;
        end else begin
          slot       = front_dec;
          front_nxt  = front_dec;
          ctrl.wr_en = 1'b1;
          count_nxt  = count_r + CW'(1);
        end
      end
      deq_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          ctrl.status = deq_pkg::STATUS_FULL;
        end else begin
          slot       = ring_add(front_r, count_r);
          ctrl.wr_en = 1'b1;
          count_nxt  = count_r + CW'(1);
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          ctrl.status = deq_pkg::STATUS_EMPTY;
        end else begin
          slot        = front_r;
          front_nxt   = front_inc;
          ctrl.rd_en  = 1'b1;
          ctrl.pop_ok = 1'b1;
          count_nxt   = count_r - CW'(1);
        end
      end
      deq_pkg::MODE_POP_BACK: begin
        if (empty) begin
          ctrl.status = deq_pkg::STATUS_EMPTY;
        end else begin
          slot        = ring_add(front_r, count_r - CW'(1));
          ctrl.rd_en  = 1'b1;
          ctrl.pop_ok = 1'b1;
          count_nxt   = count_r - CW'(1);
        end
      end
      default: begin
        ctrl.status = deq_pkg::STATUS_DONE;
      end
    endcase
  end

  assign occ_nxt = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
